### src/lpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_pkg: shared types and constants of the scanline lane pair finder
// Field widths, register map, reset values, sequencer states and the
// command bundle from the pair sequencer to the run tracker.
// ----------------------------------------------------------------------------
package lpf_pkg;

    localparam int POS_W     = 11;
    localparam int PIX_W     = 8;
    localparam int THR_W     = 8;
    localparam int LW_W      = 8;
    localparam int TW_W      = 11;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_THRESH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LW_MIN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LW_MAX = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TW_MIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TW_MAX = 3'd4;

    localparam logic [THR_W-1:0] THRESH_RST = 8'd200;
    localparam logic [LW_W-1:0]  LW_MIN_RST = 8'd3;
    localparam logic [LW_W-1:0]  LW_MAX_RST = 8'd9;
    localparam logic [TW_W-1:0]  TW_MIN_RST = 11'd117;
    localparam logic [TW_W-1:0]  TW_MAX_RST = 11'd143;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_FETCH,
        ST_CHECK,
        ST_FINISH
    } t_seq_state;

    typedef struct packed {
        logic take_pixel;
        logic close_run;
        logic clear_row;
    } t_trk_cmd;

endpackage

### src/lpf_run_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_run_tracker: column marking and run detection
// Keeps the brightness window, marks columns, follows runs of marked
// columns and writes accepted line centers into the center store.
// ----------------------------------------------------------------------------
module lpf_run_tracker #(
    parameter int MAX_COLS    = 2048,
    parameter int MAX_CENTERS = 8,
    parameter int WINDOW_SIZE = 5,
    localparam int COL_W  = $clog2(MAX_COLS),
    localparam int CIDX_W = $clog2(MAX_CENTERS),
    localparam int CC_W   = $clog2(MAX_CENTERS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lpf_pkg::t_trk_cmd           i_cmd,
    input  logic [lpf_pkg::PIX_W-1:0]   i_pixel,
    input  logic [lpf_pkg::THR_W-1:0]   i_thresh,
    input  logic [lpf_pkg::LW_W-1:0]    i_lw_min,
    input  logic [lpf_pkg::LW_W-1:0]    i_lw_max,
    output logic                        o_wr_en,
    output logic [CIDX_W-1:0]           o_wr_addr,
    output logic [COL_W-1:0]            o_wr_data,
    output logic [CC_W-1:0]             o_center_count,
    output logic                        o_overflow
);

    localparam int H      = (WINDOW_SIZE - 1) / 2;
    localparam int HIST_W = (H > 0) ? 2 * H : 1;
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int LEN_W  = (CNT_W > lpf_pkg::LW_W) ? CNT_W : lpf_pkg::LW_W;
    localparam logic [HIST_W:0]   WIN_MASK  = (HIST_W + 1)'((1 << (2 * H + 1)) - 1);
    localparam logic [HIST_W-1:0] HIST_MASK = HIST_W'((1 << (2 * H)) - 1);

    logic [HIST_W-1:0] r_hist,   n_hist;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              r_active, n_active;
    logic [COL_W-1:0]  r_start,  n_start;
    logic [CNT_W-1:0]  r_len,    n_len;
    logic [CC_W-1:0]   r_cc,     n_cc;
    logic              r_ovf,    n_ovf;

    logic              bright;
    logic [HIST_W:0]   window;
    logic              marked;
    logic              col_ok;
    logic              row_room;
    logic [COL_W-1:0]  col;
    logic              len_ok;
    logic              has_space;
    logic              do_close;

    assign bright    = (i_pixel >= i_thresh);
    assign window    = {r_hist, bright} & WIN_MASK;
    assign marked    = |window;
    assign col_ok    = (r_count >= CNT_W'(2 * H));
    assign row_room  = (r_count < CNT_W'(MAX_COLS));
    assign col       = COL_W'(r_count - CNT_W'(H));
    assign len_ok    = (LEN_W'(r_len) >= LEN_W'(i_lw_min)) &&
                       (LEN_W'(r_len) <= LEN_W'(i_lw_max));
    assign has_space = (r_cc < CC_W'(MAX_CENTERS));

    assign o_wr_addr      = r_cc[CIDX_W-1:0];
    assign o_wr_data      = r_start + COL_W'(r_len >> 1);
    assign o_center_count = r_cc;
    assign o_overflow     = r_ovf;

    always_comb begin
        n_hist   = r_hist;
        n_count  = r_count;
        n_active = r_active;
        n_start  = r_start;
        n_len    = r_len;
        n_cc     = r_cc;
        n_ovf    = r_ovf;
        o_wr_en  = 1'b0;
        do_close = 1'b0;
        if (i_cmd.clear_row) begin
            n_hist   = '0;
            n_count  = '0;
            n_active = 1'b0;
            n_start  = '0;
            n_len    = '0;
            n_cc     = '0;
            n_ovf    = 1'b0;
        end else begin
            if (i_cmd.take_pixel && row_room) begin
                n_hist  = window[HIST_W-1:0] & HIST_MASK;
                n_count = r_count + CNT_W'(1);
                if (col_ok) begin
                    if (marked) begin
                        if (!r_active) begin
                            n_active = 1'b1;
                            n_start  = col;
                            n_len    = CNT_W'(1);
                        end else begin
                            n_len = r_len + CNT_W'(1);
                        end
                    end else if (r_active) begin
                        do_close = 1'b1;
                    end
                end
            end else if (i_cmd.close_run) begin
                do_close = 1'b1;
            end
            if (do_close) begin
                // keep the center only if the run length is inside the bounds
                if (r_active && len_ok) begin
                    if (has_space) begin
                        o_wr_en = 1'b1;
                        n_cc    = r_cc + CC_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_active = 1'b0;
                n_len    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_count  <= '0;
            r_active <= 1'b0;
            r_start  <= '0;
            r_len    <= '0;
            r_cc     <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_hist   <= n_hist;
            r_count  <= n_count;
            r_active <= n_active;
            r_start  <= n_start;
            r_len    <= n_len;
            r_cc     <= n_cc;
            r_ovf    <= n_ovf;
        end
    end

endmodule

### src/lpf_center_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_center_ram: line center store
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module lpf_center_ram #(
    parameter int DEPTH  = 8,
    parameter int DATA_W = 11,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0] o_rd_data_a,
    output logic [DATA_W-1:0] o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### src/lpf_pair_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_pair_seq: row-end pair sequencer
// Walks all center pairs through one shared subtract and range compare,
// holds one pending pair so the final one can carry last, and drives the
// output register.
// ----------------------------------------------------------------------------
module lpf_pair_seq #(
    parameter int MAX_COLS    = 2048,
    parameter int MAX_CENTERS = 8,
    localparam int COL_W  = $clog2(MAX_COLS),
    localparam int CIDX_W = $clog2(MAX_CENTERS),
    localparam int CC_W   = $clog2(MAX_CENTERS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_end_of_row,
    output logic                        o_in_ready,
    output lpf_pkg::t_trk_cmd           o_cmd,
    input  logic [CC_W-1:0]             i_center_count,
    input  logic                        i_overflow,
    output logic [CIDX_W-1:0]           o_rd_addr_a,
    output logic [CIDX_W-1:0]           o_rd_addr_b,
    input  logic [COL_W-1:0]            i_rd_data_a,
    input  logic [COL_W-1:0]            i_rd_data_b,
    input  logic [lpf_pkg::TW_W-1:0]    i_tw_min,
    input  logic [lpf_pkg::TW_W-1:0]    i_tw_max,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [lpf_pkg::POS_W-1:0]   o_left_pos,
    output logic [lpf_pkg::POS_W-1:0]   o_right_pos,
    output logic                        o_pair_valid,
    output logic                        o_centers_dropped,
    output logic                        o_last
);

    localparam int DIST_W = (COL_W > lpf_pkg::TW_W) ? COL_W : lpf_pkg::TW_W;
    localparam int CW1    = CC_W + 1;

    lpf_pkg::t_seq_state r_state, n_state;

    logic [CIDX_W-1:0]         r_i, n_i;
    logic [CIDX_W-1:0]         r_j, n_j;
    logic                      r_pend_v, n_pend_v;
    logic [COL_W-1:0]          r_pend_l, n_pend_l;
    logic [COL_W-1:0]          r_pend_r, n_pend_r;
    logic                      r_out_v, n_out_v;
    logic [lpf_pkg::POS_W-1:0] r_out_l, n_out_l;
    logic [lpf_pkg::POS_W-1:0] r_out_r, n_out_r;
    logic                      r_out_pv, n_out_pv;
    logic                      r_out_drop, n_out_drop;
    logic                      r_out_last, n_out_last;

    logic              in_fire;
    logic              out_free;
    logic [COL_W-1:0]  gap;
    logic              in_range;
    logic              pair_ok;
    logic              hit;
    logic              stall;
    logic              j_next_ok;
    logic              i_next_ok;

    // shared unit: centers are stored in rising order, so b - a is the distance
    assign gap      = i_rd_data_b - i_rd_data_a;
    assign in_range = (DIST_W'(gap) >= DIST_W'(i_tw_min)) &&
                      (DIST_W'(gap) <= DIST_W'(i_tw_max));

    assign in_fire   = i_in_valid && (r_state == lpf_pkg::ST_IDLE);
    assign out_free  = !r_out_v || i_out_ready;
    assign pair_ok   = (CC_W'(r_j) < i_center_count);
    assign hit       = (r_state == lpf_pkg::ST_CHECK) && pair_ok && in_range;
    assign stall     = hit && r_pend_v && !out_free;
    assign j_next_ok = (CW1'(r_j) + CW1'(1)) < CW1'(i_center_count);
    assign i_next_ok = (CW1'(r_i) + CW1'(2)) < CW1'(i_center_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpf_pkg::ST_IDLE: begin
                if (in_fire && i_end_of_row) begin
                    n_state = lpf_pkg::ST_CLOSE;
                end
            end
            lpf_pkg::ST_CLOSE: n_state = lpf_pkg::ST_FETCH;
            lpf_pkg::ST_FETCH: n_state = lpf_pkg::ST_CHECK;
            lpf_pkg::ST_CHECK: begin
                if (!stall) begin
                    if (j_next_ok || i_next_ok) begin
                        n_state = lpf_pkg::ST_FETCH;
                    end else begin
                        n_state = lpf_pkg::ST_FINISH;
                    end
                end
            end
            lpf_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = lpf_pkg::ST_IDLE;
                end
            end
            default: n_state = lpf_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready         = (r_state == lpf_pkg::ST_IDLE);
        o_cmd.take_pixel   = in_fire;
        o_cmd.close_run    = (r_state == lpf_pkg::ST_CLOSE);
        o_cmd.clear_row    = (r_state == lpf_pkg::ST_FINISH) && out_free;
    end

    // indices, pending pair and output register
    always_comb begin
        n_i        = r_i;
        n_j        = r_j;
        n_pend_v   = r_pend_v;
        n_pend_l   = r_pend_l;
        n_pend_r   = r_pend_r;
        n_out_v    = r_out_v && !i_out_ready;
        n_out_l    = r_out_l;
        n_out_r    = r_out_r;
        n_out_pv   = r_out_pv;
        n_out_drop = r_out_drop;
        n_out_last = r_out_last;
        case (r_state)
            lpf_pkg::ST_CLOSE: begin
                n_i      = '0;
                n_j      = CIDX_W'(1);
                n_pend_v = 1'b0;
            end
            lpf_pkg::ST_CHECK: begin
                if (!stall) begin
                    if (hit) begin
                        // push the older pair out, it is not the last one
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_l    = lpf_pkg::POS_W'(r_pend_l);
                            n_out_r    = lpf_pkg::POS_W'(r_pend_r);
                            n_out_pv   = 1'b1;
                            n_out_drop = i_overflow;
                            n_out_last = 1'b0;
                        end
                        n_pend_v = 1'b1;
                        n_pend_l = i_rd_data_a;
                        n_pend_r = i_rd_data_b;
                    end
                    if (j_next_ok) begin
                        n_j = CIDX_W'(r_j + CIDX_W'(1));
                    end else if (i_next_ok) begin
                        n_i = CIDX_W'(r_i + CIDX_W'(1));
                        n_j = CIDX_W'(CW1'(r_i) + CW1'(2));
                    end
                end
            end
            lpf_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_pv   = r_pend_v;
                    n_out_l    = r_pend_v ? lpf_pkg::POS_W'(r_pend_l) : '0;
                    n_out_r    = r_pend_v ? lpf_pkg::POS_W'(r_pend_r) : '0;
                    n_out_drop = i_overflow;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lpf_pkg::ST_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_l   <= n_pend_l;
        r_pend_r   <= n_pend_r;
        r_out_l    <= n_out_l;
        r_out_r    <= n_out_r;
        r_out_pv   <= n_out_pv;
        r_out_drop <= n_out_drop;
        r_out_last <= n_out_last;
    end

    assign o_rd_addr_a       = r_i;
    assign o_rd_addr_b       = r_j;
    assign o_out_valid       = r_out_v;
    assign o_left_pos        = r_out_l;
    assign o_right_pos       = r_out_r;
    assign o_pair_valid      = r_out_pv;
    assign o_centers_dropped = r_out_drop;
    assign o_last            = r_out_last;

endmodule

### src/scanline_lane_pair_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_lane_pair_finder_unit: scan row lane pair finder
// Marks bright columns of a grey scan row, turns runs of suitable width
// into line centers and, at row end, reports every center pair whose
// distance fits the track width bounds.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  --------------------------------
//  pixel in  in         i_in_valid / o_in_ready   i_pixel, i_end_of_row
//  pair out  out        o_out_valid / i_out_ready o_left_pos, o_right_pos,
//                                                 o_pair_valid, o_centers_dropped,
//                                                 o_last
//  config    in         APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
//  A mid-row pixel is taken in the idle state and folded into the window
//  and run logic at the same edge.
//  A row-end pixel adds a close state that ends the open run, then a fetch
//  and a check state per center pair (read, then subtract and compare in the
//  shared distance unit), at least one such pass even with fewer than two
//  centers and at most MAX_CENTERS*(MAX_CENTERS-1)/2 pairs, and a finish state
//  that flushes the final result; the input stays not ready throughout.
//  Reset is synchronous, active low; it restores register defaults and
//  clears row state. The center store has no reset.
//  A stalled output holds the sequencer only when a new result needs the
//  output register; otherwise the next row's pixels keep flowing.
//
module scanline_lane_pair_finder_unit #(
    parameter int MAX_COLS    = 2048,
    parameter int MAX_CENTERS = 8,
    parameter int WINDOW_SIZE = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lpf_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_end_of_row,
    // pair output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lpf_pkg::POS_W-1:0]     o_left_pos,
    output logic [lpf_pkg::POS_W-1:0]     o_right_pos,
    output logic                          o_pair_valid,
    output logic                          o_centers_dropped,
    output logic                          o_last,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpf_pkg::PADDR_W-1:0]   paddr,
    input  logic [lpf_pkg::PDATA_W-1:0]   pwdata,
    output logic [lpf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CIDX_W = $clog2(MAX_CENTERS);
    localparam int CC_W   = $clog2(MAX_CENTERS + 1);

    // configuration registers
    logic [lpf_pkg::THR_W-1:0] r_thresh;
    logic [lpf_pkg::LW_W-1:0]  r_lw_min;
    logic [lpf_pkg::LW_W-1:0]  r_lw_max;
    logic [lpf_pkg::TW_W-1:0]  r_tw_min;
    logic [lpf_pkg::TW_W-1:0]  r_tw_max;

    logic                              cfg_wr;
    logic [lpf_pkg::REG_IDX_W-1:0]     reg_idx;

    lpf_pkg::t_trk_cmd  trk_cmd;
    logic               wr_en;
    logic [CIDX_W-1:0]  wr_addr;
    logic [COL_W-1:0]   wr_data;
    logic [CC_W-1:0]    center_count;
    logic               overflow;
    logic [CIDX_W-1:0]  rd_addr_a;
    logic [CIDX_W-1:0]  rd_addr_b;
    logic [COL_W-1:0]   rd_data_a;
    logic [COL_W-1:0]   rd_data_b;

    // the bus never waits; a write lands on the access cycle
    assign pready  = 1'b1;
    assign reg_idx = paddr[lpf_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= lpf_pkg::THRESH_RST;
            r_lw_min <= lpf_pkg::LW_MIN_RST;
            r_lw_max <= lpf_pkg::LW_MAX_RST;
            r_tw_min <= lpf_pkg::TW_MIN_RST;
            r_tw_max <= lpf_pkg::TW_MAX_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                lpf_pkg::REG_THRESH: r_thresh <= pwdata[lpf_pkg::THR_W-1:0];
                lpf_pkg::REG_LW_MIN: r_lw_min <= pwdata[lpf_pkg::LW_W-1:0];
                lpf_pkg::REG_LW_MAX: r_lw_max <= pwdata[lpf_pkg::LW_W-1:0];
                lpf_pkg::REG_TW_MIN: r_tw_min <= pwdata[lpf_pkg::TW_W-1:0];
                lpf_pkg::REG_TW_MAX: r_tw_max <= pwdata[lpf_pkg::TW_W-1:0];
                default: ;  // drop writes outside the map
            endcase
        end
    end

    // read back, zero-extended; unmapped addresses read zero
    always_comb begin
        case (reg_idx)
            lpf_pkg::REG_THRESH: prdata = lpf_pkg::PDATA_W'(r_thresh);
            lpf_pkg::REG_LW_MIN: prdata = lpf_pkg::PDATA_W'(r_lw_min);
            lpf_pkg::REG_LW_MAX: prdata = lpf_pkg::PDATA_W'(r_lw_max);
            lpf_pkg::REG_TW_MIN: prdata = lpf_pkg::PDATA_W'(r_tw_min);
            lpf_pkg::REG_TW_MAX: prdata = lpf_pkg::PDATA_W'(r_tw_max);
            default:             prdata = '0;
        endcase
    end

    // window, marking and run tracking; writes centers into the store
    lpf_run_tracker #(
        .MAX_COLS    (MAX_COLS),
        .MAX_CENTERS (MAX_CENTERS),
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (trk_cmd),
        .i_pixel        (i_pixel),
        .i_thresh       (r_thresh),
        .i_lw_min       (r_lw_min),
        .i_lw_max       (r_lw_max),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_center_count (center_count),
        .o_overflow     (overflow)
    );

    // center store, read at both pair indices
    lpf_center_ram #(
        .DEPTH  (MAX_CENTERS),
        .DATA_W (COL_W)
    ) u_centers (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    // handshake, row-end sequencing and pair enumeration
    lpf_pair_seq #(
        .MAX_COLS    (MAX_COLS),
        .MAX_CENTERS (MAX_CENTERS)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_end_of_row      (i_end_of_row),
        .o_in_ready        (o_in_ready),
        .o_cmd             (trk_cmd),
        .i_center_count    (center_count),
        .i_overflow        (overflow),
        .o_rd_addr_a       (rd_addr_a),
        .o_rd_addr_b       (rd_addr_b),
        .i_rd_data_a       (rd_data_a),
        .i_rd_data_b       (rd_data_b),
        .i_tw_min          (r_tw_min),
        .i_tw_max          (r_tw_max),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_left_pos        (o_left_pos),
        .o_right_pos       (o_right_pos),
        .o_pair_valid      (o_pair_valid),
        .o_centers_dropped (o_centers_dropped),
        .o_last            (o_last)
    );

endmodule

### src/lpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_checker: port-level checks for the lane pair finder
// Watches the top-level ports and is bound onto every instance.
// ----------------------------------------------------------------------------
module lpf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_end_of_row,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [lpf_pkg::POS_W-1:0]     o_left_pos,
    input logic [lpf_pkg::POS_W-1:0]     o_right_pos,
    input logic                          o_pair_valid,
    input logic                          o_centers_dropped,
    input logic                          o_last
);

    // a stalled result holds its valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
            $stable(o_left_pos) && $stable(o_right_pos) && $stable(o_pair_valid) &&
            $stable(o_centers_dropped) && $stable(o_last))
        else $error("output changed while stalled");

    // a row-end transfer starts pair enumeration, so input must close
    a_eor_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_end_of_row |=> !o_in_ready)
        else $error("input ready right after row end");

    // an empty row marker is always the final result and carries no positions
    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pair_valid |-> o_last && (o_left_pos == '0) &&
            (o_right_pos == '0))
        else $error("malformed empty row marker");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind scanline_lane_pair_finder_unit lpf_checker u_lpf_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the scanline lane pair finder
// Streams grey scan rows into the block under random idling on both sides,
// keeps its own copy of the column marking, run and pairing logic, and
// compares every pair transfer with the oldest predicted one. Directed rows
// cover reset defaults with track bounds hit exactly, row edges, pair order,
// center overflow and inverted bounds; random rows follow under varied
// settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int POS_W     = lpf_pkg::POS_W;
    localparam int PIX_W     = lpf_pkg::PIX_W;
    localparam int THR_W     = lpf_pkg::THR_W;
    localparam int LW_W      = lpf_pkg::LW_W;
    localparam int TW_W      = lpf_pkg::TW_W;
    localparam int PADDR_W   = lpf_pkg::PADDR_W;
    localparam int PDATA_W   = lpf_pkg::PDATA_W;
    localparam int REG_IDX_W = lpf_pkg::REG_IDX_W;

    localparam int CLK_HALF      = 4;
    localparam int RST_CYCLES    = 7;
    localparam int MAX_COLS      = 2048;
    localparam int MAX_CENTERS   = 8;
    localparam int HALF_WIN      = 2;
    localparam int IDLE_PCT      = 24;
    // row end: close, a fetch and a check per pair, flush; round up generously
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PIXELS = 40;
    localparam int ERR_PRINT_MAX = 40;

    // power-on register values as the block documents them
    localparam int DEF_THRESH = 200;
    localparam int DEF_LW_MIN = 3;
    localparam int DEF_LW_MAX = 9;
    localparam int DEF_TW_MIN = 117;
    localparam int DEF_TW_MAX = 143;

    typedef struct packed {
        logic [POS_W-1:0] left_pos;
        logic [POS_W-1:0] right_pos;
        logic             pair_valid;
        logic             centers_dropped;
        logic             last;
    } t_pair_result;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [PIX_W-1:0]   i_pixel = '0;
    logic               i_end_of_row = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [POS_W-1:0]   o_left_pos;
    logic [POS_W-1:0]   o_right_pos;
    logic               o_pair_valid;
    logic               o_centers_dropped;
    logic               o_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    scanline_lane_pair_finder_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_pixel           (i_pixel),
        .i_end_of_row      (i_end_of_row),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_left_pos        (o_left_pos),
        .o_right_pos       (o_right_pos),
        .o_pair_valid      (o_pair_valid),
        .o_centers_dropped (o_centers_dropped),
        .o_last            (o_last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    t_pair_result     pairs_due[$];     // pairs predicted but not yet seen
    logic [PIX_W-1:0] row_buf[$];       // pixels of the row about to be sent
    int unsigned      errors = 0;
    int unsigned      pixels_sent = 0;
    int unsigned      rows_sent = 0;
    int unsigned      results_seen = 0;
    int unsigned      cfg_writes = 0;
    int unsigned      stall_cycles = 0;
    bit               calm = 1'b0;      // suppress idling on both sides

    // ------------------------------------------------------------------------
    // Row model: register copies and per-row state
    // ------------------------------------------------------------------------
    logic [THR_W-1:0] thr_cfg    = DEF_THRESH;
    logic [LW_W-1:0]  lw_min_cfg = DEF_LW_MIN;
    logic [LW_W-1:0]  lw_max_cfg = DEF_LW_MAX;
    logic [TW_W-1:0]  tw_min_cfg = DEF_TW_MIN;
    logic [TW_W-1:0]  tw_max_cfg = DEF_TW_MAX;

    logic [2*HALF_WIN-1:0] lit_hist = '0;   // brightness of the last 2*H pixels
    int unsigned           col_seen = 0;    // pixels taken in this row
    bit                    run_open = 1'b0;
    int unsigned           run_first = 0;
    int unsigned           run_len = 0;
    logic [POS_W-1:0]      ctr_store[MAX_CENTERS];
    int unsigned           ctr_num = 0;
    bit                    ctr_lost = 1'b0;

    // Judge the open run by its width and keep its center if there is room.
    function automatic void close_line_run();
        if (run_open && run_len >= lw_min_cfg && run_len <= lw_max_cfg) begin
            if (ctr_num < MAX_CENTERS) begin
                ctr_store[ctr_num] = POS_W'(run_first + run_len / 2);
                ctr_num++;
            end else begin
                ctr_lost = 1'b1;
            end
        end
        run_open = 1'b0;
        run_len  = 0;
    endfunction

    // Fold one accepted pixel into the row; at row end queue the pairs.
    function automatic void track_pixel(logic [PIX_W-1:0] pix, logic eor);
        logic [2*HALF_WIN:0] win;
        t_pair_result        held;
        bit                  have_held;
        int unsigned         a, b, gap;
        have_held = 1'b0;
        held      = '0;
        if (col_seen < MAX_COLS) begin
            win = {lit_hist, pix >= thr_cfg};
            // the first and last H columns never get a full window
            if (col_seen >= 2 * HALF_WIN) begin
                if (win != '0) begin
                    if (!run_open) begin
                        run_open  = 1'b1;
                        run_first = col_seen - HALF_WIN;
                        run_len   = 1;
                    end else begin
                        run_len++;
                    end
                end else if (run_open) begin
                    close_line_run();
                end
            end
            lit_hist = win[2*HALF_WIN-1:0];
            col_seen++;
        end
        if (eor) begin
            close_line_run();
            for (int i = 0; i < ctr_num; i++) begin
                for (int j = i + 1; j < ctr_num; j++) begin
                    a   = ctr_store[i];
                    b   = ctr_store[j];
                    gap = (b >= a) ? b - a : a - b;
                    if (gap >= tw_min_cfg && gap <= tw_max_cfg) begin
                        // hold each pair back one step so the final one gets last
                        if (have_held) pairs_due = {pairs_due, held};
                        held.left_pos        = POS_W'(a);
                        held.right_pos       = POS_W'(b);
                        held.pair_valid      = 1'b1;
                        held.centers_dropped = ctr_lost;
                        held.last            = 1'b0;
                        have_held            = 1'b1;
                    end
                end
            end
            if (have_held) begin
                held.last = 1'b1;
            end else begin
                // empty row marker
                held.centers_dropped = ctr_lost;
                held.last            = 1'b1;
            end
            pairs_due = {pairs_due, held};
            lit_hist  = '0;
            col_seen  = 0;
            run_open  = 1'b0;
            run_first = 0;
            run_len   = 0;
            ctr_num   = 0;
            ctr_lost  = 1'b0;
        end
    endfunction

    function automatic logic [PDATA_W-1:0] cfg_value(logic [REG_IDX_W-1:0] idx);
        case (idx)
            lpf_pkg::REG_THRESH: return PDATA_W'(thr_cfg);
            lpf_pkg::REG_LW_MIN: return PDATA_W'(lw_min_cfg);
            lpf_pkg::REG_LW_MAX: return PDATA_W'(lw_max_cfg);
            lpf_pkg::REG_TW_MIN: return PDATA_W'(tw_min_cfg);
            lpf_pkg::REG_TW_MAX: return PDATA_W'(tw_max_cfg);
            default:             return '0;
        endcase
    endfunction

    function automatic void check_field(string name, logic [POS_W-1:0] want_v,
                                        logic [POS_W-1:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            if (errors <= ERR_PRINT_MAX)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random back-pressure and the result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each pair transfer with the oldest prediction.
    always @(posedge i_clk) begin : chk_proc
        t_pair_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pairs_due.size() == 0) begin
                errors++;
                if (errors <= ERR_PRINT_MAX)
                    $display({"%0t ns: unexpected result, expected none, ",
                              "actual %0d/%0d v%0b d%0b l%0b"},
                             $time, o_left_pos, o_right_pos, o_pair_valid,
                             o_centers_dropped, o_last);
            end else begin
                want = pairs_due.pop_front();
                check_field("left_pos", want.left_pos, o_left_pos);
                check_field("right_pos", want.right_pos, o_right_pos);
                check_field("pair_valid", POS_W'(want.pair_valid), POS_W'(o_pair_valid));
                check_field("centers_dropped", POS_W'(want.centers_dropped),
                            POS_W'(o_centers_dropped));
                check_field("last", POS_W'(want.last), POS_W'(o_last));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pairs_due.size());
            $display("FAIL scanline_lane_pair_finder_unit");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    // A setup phase, an access phase held until pready, and an idle phase to release the bus.
    task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input logic wr,
                              input logic [PDATA_W-1:0] data,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] unused;
        apb_access(idx, 1'b1, data, unused);
        // mirror the write, masked to the register width
        case (idx)
            lpf_pkg::REG_THRESH: thr_cfg    = data[THR_W-1:0];
            lpf_pkg::REG_LW_MIN: lw_min_cfg = data[LW_W-1:0];
            lpf_pkg::REG_LW_MAX: lw_max_cfg = data[LW_W-1:0];
            lpf_pkg::REG_TW_MIN: tw_min_cfg = data[TW_W-1:0];
            lpf_pkg::REG_TW_MAX: tw_max_cfg = data[TW_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic check_register(input logic [REG_IDX_W-1:0] idx);
        logic [PDATA_W-1:0] got;
        apb_access(idx, 1'b0, '0, got);
        if (got !== cfg_value(idx)) begin
            errors++;
            if (errors <= ERR_PRINT_MAX)
                $display("%0t ns: register %0d readback, expected 0x%0h, actual 0x%0h",
                         $time, idx, cfg_value(idx), got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Drop valid, drain every predicted pair, then let a row end finish.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pairs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned thr, input int unsigned lw_min,
                              input int unsigned lw_max, input int unsigned tw_min,
                              input int unsigned tw_max);
        settle_block();
        apb_write(lpf_pkg::REG_THRESH, PDATA_W'(thr));
        apb_write(lpf_pkg::REG_LW_MIN, PDATA_W'(lw_min));
        apb_write(lpf_pkg::REG_LW_MAX, PDATA_W'(lw_max));
        apb_write(lpf_pkg::REG_TW_MIN, PDATA_W'(tw_min));
        apb_write(lpf_pkg::REG_TW_MAX, PDATA_W'(tw_max));
    endtask

    // Send one pixel: idle at random first, then hold valid until the transfer.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic eor);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_pixel      <= pix;
        i_end_of_row <= eor;
        do @(posedge i_clk); while (!o_in_ready);
        track_pixel(pix, eor);
        pixels_sent++;
        if (eor) rows_sent++;
    endtask

    task automatic send_row();
        for (int k = 0; k < row_buf.size(); k++)
            send_pixel(row_buf[k], k == row_buf.size() - 1);
    endtask

    task automatic fill_row(input int unsigned len, input logic [PIX_W-1:0] px);
        row_buf.delete();
        repeat (len) row_buf = {row_buf, px};
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Defaults after reset; three lines whose pairs sit on both track bounds.
    task automatic test_default_bounds();
        for (int r = lpf_pkg::REG_THRESH; r <= lpf_pkg::REG_TW_MAX; r++)
            check_register(REG_IDX_W'(r));
        fill_row(152, 8'd0);
        // centers 4, 121 and 147: 117 and 143 apart from the first, 26 between
        row_buf[4]   = 8'd255;
        row_buf[121] = 8'd255;
        row_buf[147] = 8'd255;
        send_row();
    endtask

    // Walk every register through zero, all ones and both checkerboards.
    task automatic test_register_access();
        logic [PDATA_W-1:0] patterns[4];
        patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        settle_block();
        foreach (patterns[p]) begin
            for (int r = lpf_pkg::REG_THRESH; r <= lpf_pkg::REG_TW_MAX; r++) begin
                apb_write(REG_IDX_W'(r), patterns[p]);
                check_register(REG_IDX_W'(r));
            end
        end
        fill_row(8, 8'd255);
        send_row();
    endtask

    // Rows too short to mark anything or marking one column, and bright pixels at the first and last column.
    task automatic test_short_rows();
        set_config(128, 1, 9, 0, 2047);
        fill_row(1, 8'd255);
        send_row();
        fill_row(4, 8'd255);
        send_row();
        fill_row(5, 8'd255);
        send_row();
        fill_row(12, 8'd0);
        row_buf[0]  = 8'd255;
        row_buf[11] = 8'd255;
        send_row();
    endtask

    // Three lines, all pairs in order, then only the 6-apart pairs; the last
    // run is still open at row end.
    task automatic test_pair_order();
        set_config(128, 1, 5, 0, 2047);
        fill_row(20, 8'd127);
        row_buf[3]  = 8'd128;
        row_buf[10] = 8'd200;
        row_buf[17] = 8'd255;
        send_row();
        set_config(128, 1, 5, 6, 6);
        send_row();
    endtask

    // Ten lines: two are dropped and all 28 pairs of the stored eight come out.
    // Run this row with no idling on either side.
    task automatic test_center_overflow();
        set_config(128, 1, 5, 0, 2047);
        fill_row(62, 8'd0);
        for (int k = 0; k < 10; k++) row_buf[3 + 6 * k] = 8'd255;
        calm = 1'b1;
        send_row();
        settle_block();
        calm = 1'b0;
    endtask

    // Minimum above maximum for line width, then for track width.
    task automatic test_inverted_bounds();
        set_config(128, 6, 5, 0, 2047);
        fill_row(20, 8'd0);
        row_buf[3]  = 8'd255;
        row_buf[10] = 8'd255;
        send_row();
        set_config(128, 1, 5, 10, 9);
        send_row();
    endtask

    // Threshold at both ends of the pixel range.
    task automatic test_pixel_extremes();
        set_config(255, 1, 9, 0, 2047);
        fill_row(17, 8'd254);
        row_buf[4]  = 8'd255;
        row_buf[12] = 8'd255;
        send_row();
        set_config(0, 1, 9, 0, 2047);
        fill_row(10, 8'd0);
        send_row();
    endtask

    task automatic pick_random_config();
        int unsigned thr, lw_min, lw_max, tw_min, tw_max;
        case ($urandom_range(0, 5))
            0:       thr = 0;
            1:       thr = 255;
            default: thr = $urandom_range(1, 254);
        endcase
        lw_min = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        case ($urandom_range(0, 7))
            0:       lw_max = 255;
            1:       lw_max = $urandom_range(0, 255);
            default: lw_max = $urandom_range(2, 9);
        endcase
        tw_min = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 12);
        case ($urandom_range(0, 7))
            0:       tw_max = 2047;
            1:       tw_max = $urandom_range(0, 2047);
            default: tw_max = tw_min + $urandom_range(0, 40);
        endcase
        set_config(thr, lw_min, lw_max, tw_min, tw_max);
    endtask

    // Mostly dark rows with bright bursts; some rows are pure noise.
    task automatic build_random_row();
        int unsigned len;
        bit          noise;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 48);
        noise = ($urandom_range(0, 4) == 0);
        row_buf.delete();
        while (row_buf.size() < len) begin
            if (noise || thr_cfg == 0) begin
                row_buf = {row_buf, PIX_W'($urandom_range(0, 255))};
            end else begin
                repeat ($urandom_range(1, 7))
                    if (row_buf.size() < len)
                        row_buf = {row_buf, PIX_W'($urandom_range(0, thr_cfg - 1))};
                repeat ($urandom_range(1, 4))
                    if (row_buf.size() < len)
                        row_buf = {row_buf, PIX_W'($urandom_range(thr_cfg, 255))};
            end
        end
    endtask

    // Phases of a few rows each under a fresh setting.
    task automatic test_random_rows();
        int unsigned first_px;
        first_px = pixels_sent;
        while (pixels_sent - first_px < RANDOM_PIXELS) begin
            pick_random_config();
            repeat ($urandom_range(2, 4)) begin
                build_random_row();
                send_row();
            end
        end
        settle_block();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_bounds();
        test_register_access();
        test_short_rows();
        test_pair_order();
        test_center_overflow();
        test_inverted_bounds();
        test_pixel_extremes();
        test_random_rows();

        settle_block();
        $display("Ran %0d rows, %0d pixels, %0d results checked, %0d register writes.",
                 rows_sent, pixels_sent, results_seen, cfg_writes);
        $display("Directed edge, overflow and bound cases, then random rows under varied settings.");
        if (errors == 0) begin
            $display("PASS scanline_lane_pair_finder_unit");
        end else begin
            $display("FAIL scanline_lane_pair_finder_unit");
        end
        $finish;
    end

endmodule

### files.f
src/lpf_pkg.sv
src/lpf_run_tracker.sv
src/lpf_center_ram.sv
src/lpf_pair_seq.sv
src/scanline_lane_pair_finder_unit.sv
src/lpf_checker.sv
tb/sv/tb_top.sv
